### rtl/svbf_pkg.sv
`default_nettype none
package svbf_pkg;

	localparam int LEDS_PER_SIDE_DEF = 8;

	localparam int LEVEL_W = 16;
	localparam int FS_W    = 8;
	localparam int METER_W = 13;	// (65535*255)>>11 fits in 13 bits

	localparam logic [FS_W-1:0] FS_RESET = 8'd255;
	localparam logic [7:0]      LED_HDR  = 8'hEF;
	localparam logic [2:0]      BC_FULL  = 3'd4;
	localparam logic [2:0]      BC_LAST  = 3'd1;

	typedef logic [METER_W-1:0] meter_t;

	typedef struct packed {
		meter_t meter_l;
		meter_t meter_r;
		logic [FS_W-1:0] fs;
	} entry_t;

	typedef struct packed {
		logic   vld;
		entry_t ent;
	} q_head_t;

	// x / 255 for x < 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [7:0] blue_coef(input logic [2:0] idx);
		return 8'd255 - {idx, 5'b0};
	endfunction

	function automatic logic [7:0] red_coef(input logic [2:0] idx);
		return {2'b0, idx, 3'b0};
	endfunction

endpackage
`default_nettype wire

### rtl/svbf_front.sv
`default_nettype none
module svbf_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [svbf_pkg::FS_W-1:0]   cfg_data,
	input  wire logic [svbf_pkg::LEVEL_W-1:0] left_level,
	input  wire logic [svbf_pkg::LEVEL_W-1:0] right_level,
	output svbf_pkg::entry_t                 ent
);
	import svbf_pkg::*;

	logic [FS_W-1:0] fs_q;
	logic [LEVEL_W+FS_W-1:0] prod_l, prod_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= FS_RESET;
		end else if (cfg_we) begin
			fs_q <= cfg_data;
		end
	end

	// level*8*fs >> 14 == level*fs >> 11
	assign prod_l = left_level * fs_q;
	assign prod_r = right_level * fs_q;

	assign ent.meter_l = prod_l[LEVEL_W+FS_W-1:11];
	assign ent.meter_r = prod_r[LEVEL_W+FS_W-1:11];
	assign ent.fs      = fs_q;

endmodule
`default_nettype wire

### rtl/svbf_queue.sv
`default_nettype none
module svbf_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire svbf_pkg::entry_t wr_ent,
	input  wire logic             pop,
	output logic                  full,
	output svbf_pkg::q_head_t     head
);
	import svbf_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full     = cnt_q[1];
	assign head.vld = (cnt_q != 2'd0);
	assign head.ent = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

### rtl/svbf_back.sv
`default_nettype none
module svbf_back #(
	parameter int LEDS_PER_SIDE = svbf_pkg::LEDS_PER_SIDE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire svbf_pkg::q_head_t head,
	output logic                   pop,
	output logic                   word_strobe,
	output logic [31:0]            frame_word,
	output logic [2:0]             byte_count,
	output logic                   last_word
);
	import svbf_pkg::*;

	localparam int NW = 2 * LEDS_PER_SIDE + 3;
	localparam int KW = $clog2(NW);
	localparam int IW = (LEDS_PER_SIDE > 1) ? $clog2(LEDS_PER_SIDE) : 1;
	localparam logic [KW-1:0] K_R_LAST = KW'(LEDS_PER_SIDE);
	localparam logic [KW-1:0] K_L_LAST = KW'(2 * LEDS_PER_SIDE);
	localparam logic [KW-1:0] K_END    = KW'(NW - 1);

	logic [KW-1:0] k_q;
	logic          is_r, is_l, is_led;
	logic [KW-1:0] idx_k;
	logic [IW-1:0] idx;
	meter_t        meter;
	logic [10:0]   base;
	meter_t        diff;
	logic [FS_W-1:0] bar;

	// stage 1: bar level
	logic          vld_s1, led_s1, last_s1;
	logic [2:0]    idx_s1;
	logic [7:0]    bar_s1;
	// stage 2: color products
	logic          vld_s2, led_s2, last_s2;
	logic [15:0]   blue_p_s2, red_p_s2;

	assign pop = head.vld && (k_q == K_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (head.vld) begin
			k_q <= pop ? '0 : k_q + KW'(1);
		end
	end

	// word 0 is the start word, right LEDs run high to low, left LEDs low to high
	always_comb begin
		is_r   = (k_q != '0) && (k_q <= K_R_LAST);
		is_l   = (k_q > K_R_LAST) && (k_q <= K_L_LAST);
		is_led = is_r || is_l;
		idx_k  = is_r ? (K_R_LAST - k_q) : (k_q - K_R_LAST - KW'(1));
		idx    = idx_k[IW-1:0];
		meter  = is_r ? head.ent.meter_r : head.ent.meter_l;
		base   = 11'(idx) * 11'(head.ent.fs);
		diff   = (meter > METER_W'(base)) ? (meter - METER_W'(base)) : '0;
		bar    = (diff > METER_W'(head.ent.fs)) ? head.ent.fs : diff[FS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			word_strobe <= 1'b0;
		end else begin
			vld_s1      <= head.vld;
			vld_s2      <= vld_s1;
			word_strobe <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		led_s1  <= is_led;
		last_s1 <= pop;
		idx_s1  <= 3'(idx);
		bar_s1  <= bar;

		led_s2    <= led_s1;
		last_s2   <= last_s1;
		blue_p_s2 <= blue_coef(idx_s1) * bar_s1;
		red_p_s2  <= red_coef(idx_s1) * bar_s1;

		frame_word <= led_s2 ? {LED_HDR, div255(blue_p_s2), 8'h00, div255(red_p_s2)} : 32'd0;
		byte_count <= last_s2 ? BC_LAST : BC_FULL;
		last_word  <= last_s2;
	end

endmodule
`default_nettype wire

### rtl/stereo_vu_bar_led_framer.sv
`default_nettype none
// Stereo VU bar frame builder. A level pair is taken when start is high and busy is low;
// each pair becomes one LED frame of 2*LEDS_PER_SIDE+3 words (19 by default), given out
// one word per cycle on word_strobe, the first word reaching the ports through the queue
// and the vld_s1, vld_s2 and word_strobe registers. The word sequencer in the back end sets
// the pace: frames follow each other without gaps while a pair waits. A two-entry
// queue between the input side and the sequencer holds pairs that wait, and busy is high
// while it is full. The receiver cannot stall: every word is valid for exactly one cycle.
// Write the brightness register (cfg_we, cfg_data) only while no frame is pending.
module stereo_vu_bar_led_framer #(
	parameter int LEDS_PER_SIDE = svbf_pkg::LEDS_PER_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] left_level,
	input  wire logic [15:0] right_level,
	output logic             word_strobe,
	output logic [31:0]      frame_word,
	output logic [2:0]       byte_count,
	output logic             last_word
);
	import svbf_pkg::*;

	entry_t  ent;
	q_head_t head;
	logic    pop;
	logic    full;

	svbf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.left_level  (left_level),
		.right_level (right_level),
		.ent         (ent)
	);

	svbf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (start && !full),
		.wr_ent (ent),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	svbf_back #(
		.LEDS_PER_SIDE (LEDS_PER_SIDE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.word_strobe (word_strobe),
		.frame_word  (frame_word),
		.byte_count  (byte_count),
		.last_word   (last_word)
	);

	assign busy = full;

endmodule
`default_nettype wire
